### hw/rtl/ppfu_pkg.sv
// ----------------------------------------------------------------------------
// ppfu_pkg
// Types and constants shared by the packed pixel format unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package ppfu_pkg;

  // Color modes held in the color_mode register.
  typedef enum logic [1:0] {
    MODE_PALETTE    = 2'd0,
    MODE_GREY       = 2'd1,
    MODE_GREY_ALPHA = 2'd2,
    MODE_PASS       = 2'd3
  } mode_t;

  // Register indexes on the configuration port.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_CODE = 2'd1;

  // Palette depth codes; the eight-bit code is also used for whole-byte results.
  localparam logic [1:0] DEPTH_1 = 2'd0;
  localparam logic [1:0] DEPTH_2 = 2'd1;
  localparam logic [1:0] DEPTH_4 = 2'd2;
  localparam logic [1:0] DEPTH_8 = 2'd3;

  // Result count of a grey byte (R, G, B) and of a copied byte.
  localparam logic [3:0] GREY_COUNT = 4'd3;
  localparam logic [3:0] PASS_COUNT = 4'd1;
  localparam logic [3:0] BYTE_BITS  = 4'd8;

  // Depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  // One classified byte: what the back end must emit for it.
  typedef struct packed {
    logic [7:0] data;       // source byte
    logic [3:0] count;      // number of results, 1 to 8
    logic [1:0] depth;      // pixel width code for palette unpacking
    logic       hold_byte;  // repeat the whole byte instead of shifting
  } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/ppfu_ifs.sv
// ----------------------------------------------------------------------------
// ppfu_ifs
// Valid/ready stream interfaces for source bytes and result bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppfu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       image_end;

  modport source (output valid, output data_byte, output image_end, input ready);
  modport sink (input valid, input data_byte, input image_end, output ready);
endinterface

interface ppfu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

`default_nettype wire

### hw/rtl/ppfu_front.sv
// ----------------------------------------------------------------------------
// ppfu_front
// Holds the configuration, accepts source bytes and classifies each into a
// command for the back end. Tracks the grey-alpha phase and drops alpha bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfu_front
  import ppfu_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  ppfu_in_if.sink                     src,
  output logic                        cmd_valid,
  input  wire logic                   cmd_ready,
  output cmd_t                        cmd
);

  mode_t      color_mode;
  logic [1:0] depth_code;
  logic       alpha_phase;
  logic       alpha_phase_next;
  logic       accept;
  logic       drop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= MODE_PALETTE;
      depth_code <= DEPTH_8;
    end else if (cfg_we) begin
      if (cfg_index == REG_COLOR_MODE) begin
        color_mode <= mode_t'(cfg_data);
      end else if (cfg_index == REG_DEPTH_CODE) begin
        depth_code <= cfg_data;
      end
    end
  end

  // A byte is taken whenever the queue has room, even one that is dropped.
  assign src.ready = cmd_ready;
  assign accept    = src.valid && cmd_ready;
  assign drop      = (color_mode == MODE_GREY_ALPHA) && alpha_phase;
  assign cmd_valid = src.valid && !drop;

  // Classify the byte by mode.
  always_comb begin
    cmd.data      = src.data_byte;
    cmd.depth     = DEPTH_8;
    cmd.hold_byte = 1'b1;
    cmd.count     = PASS_COUNT;
    unique case (color_mode)
      MODE_PALETTE: begin
        cmd.depth     = depth_code;
        cmd.hold_byte = 1'b0;
        cmd.count     = BYTE_BITS >> depth_code;
      end
      MODE_GREY, MODE_GREY_ALPHA: begin
        cmd.count = GREY_COUNT;
      end
      MODE_PASS: begin
        cmd.count = PASS_COUNT;
      end
      default: begin
        cmd.count = PASS_COUNT;
      end
    endcase
  end

  // Alpha phase toggles on each grey-alpha byte and clears at image end.
  always_comb begin
    alpha_phase_next = alpha_phase;
    if (accept) begin
      if (color_mode == MODE_GREY_ALPHA) begin
        alpha_phase_next = !alpha_phase;
      end
      if (src.image_end) begin
        alpha_phase_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_phase <= 1'b0;
    end else begin
      alpha_phase <= alpha_phase_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ppfu_queue.sv
// ----------------------------------------------------------------------------
// ppfu_queue
// Short command queue that lets the front and the back end stall separately.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfu_queue
  import ppfu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  cmd_t      push_cmd,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_cmd
);

  cmd_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] fill;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (fill != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ppfu_back.sv
// ----------------------------------------------------------------------------
// ppfu_back
// Runs queued commands: emits one result byte per cycle unless dst stalls, via
// a registered output, unpacking palette pixels or repeating whole bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfu_back
  import ppfu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  ppfu_out_if.source dst
);

  logic       cur_valid;
  logic [7:0] cur_data;
  logic [3:0] cur_remaining;
  logic [1:0] cur_depth;
  logic       cur_hold;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       run_last;
  logic       slot_free;
  logic       emit;
  logic       cur_last;
  logic [7:0] pixel;
  logic [7:0] data_shifted;

  assign slot_free = !out_valid || dst.ready;
  assign emit      = slot_free && cur_valid;
  assign cur_last  = (cur_remaining == 4'd1);
  assign cmd_ready = !cur_valid || (emit && cur_last);

  // Top pixel of the working byte and the byte with it shifted out.
  always_comb begin
    case (cur_depth)
      DEPTH_1: begin
        pixel        = {7'd0, cur_data[7]};
        data_shifted = {cur_data[6:0], 1'b0};
      end
      DEPTH_2: begin
        pixel        = {6'd0, cur_data[7:6]};
        data_shifted = {cur_data[5:0], 2'b0};
      end
      DEPTH_4: begin
        pixel        = {4'd0, cur_data[7:4]};
        data_shifted = {cur_data[3:0], 4'b0};
      end
      default: begin
        pixel        = cur_data;
        data_shifted = cur_data;
      end
    endcase
  end

  // Working command register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (cmd_valid && cmd_ready) begin
      cur_valid <= 1'b1;
    end else if (emit && cur_last) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cur_data      <= cmd.data;
      cur_remaining <= cmd.count;
      cur_depth     <= cmd.depth;
      cur_hold      <= cmd.hold_byte;
    end else if (emit) begin
      cur_remaining <= cur_remaining - 4'd1;
      if (!cur_hold) begin
        cur_data <= data_shifted;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (dst.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= pixel;
      run_last <= cur_last;
    end
  end

  assign dst.valid    = out_valid;
  assign dst.out_byte = out_byte;
  assign dst.run_last = run_last;

endmodule

`default_nettype wire

### hw/rtl/packed_pixel_format_unpacker.sv
// ----------------------------------------------------------------------------
// packed_pixel_format_unpacker
// Reformats decoded image bytes into palette indexes, RGB triples or copies.
// ----------------------------------------------------------------------------
// The block takes one source byte per transaction and produces result bytes
// one per cycle from a single output register unless pix_out stalls; a byte
// gives 8 >> depth_code results in palette mode (8, 4, 2 or 1), three in the
// grey modes, one in passthrough; an alpha byte in grey-alpha mode is taken
// and gives no result. A two-entry command queue sits between the input
// classifier and the output emitter, so new bytes are taken while earlier
// results are still being delivered. The user writes configuration through
// cfg_we, cfg_index and cfg_data only while the block is idle (not enforced).
`default_nettype none

module packed_pixel_format_unpacker
  import ppfu_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  ppfu_in_if.sink                     pix_in,
  ppfu_out_if.source                  pix_out
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  // Classifier and configuration.
  ppfu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src       (pix_in),
    .cmd_valid (push_valid),
    .cmd_ready (push_ready),
    .cmd       (push_cmd)
  );

  // Command queue.
  ppfu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Result emitter.
  ppfu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .dst       (pix_out)
  );

endmodule

`default_nettype wire

### tb/tb_packed_pixel_format_unpacker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packed_pixel_format_unpacker
// Drives source bytes into the unpacker in every color mode and pixel depth,
// predicts the result bytes of each accepted byte, and checks each result
// byte and its run_last flag in order, under several idle and stall patterns.
// ----------------------------------------------------------------------------

module tb_packed_pixel_format_unpacker;
  import ppfu_pkg::*;

  // The two unused register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 2'd3;

  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_BLOCK = 18;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ppfu_in_if  pix_in ();
  ppfu_out_if pix_out ();

  packed_pixel_format_unpacker DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_in),
    .pix_out   (pix_out)
  );

  // Predicted state of the block: registers and the grey-alpha phase.
  mode_t      cur_mode;
  logic [1:0] cur_depth;
  logic       next_is_alpha;

  pixel_t expected_pixels[$];

  int send_idle_pct;
  int recv_stall_pct;
  int error_count;
  int bytes_sent;
  int pixels_checked;
  int cycle_count = 0;

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit; ends the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_pixels.size());
      $display("tb_packed_pixel_format_unpacker: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Works out the result bytes of one source byte and queues them.
  task automatic unpack_byte(input logic [7:0] data, input logic last_of_image);
    int     bits;
    int     count;
    int     shift;
    pixel_t px;
    case (cur_mode)
      MODE_PALETTE: begin
        bits  = 1 << cur_depth;
        count = 8 >> cur_depth;
        for (int k = 0; k < count; k++) begin
          shift = 8 - bits * (k + 1);
          px.value = 8'((data >> shift) & ((1 << bits) - 1));
          px.last  = (k == count - 1);
          expected_pixels.push_back(px);
        end
      end
      MODE_GREY, MODE_GREY_ALPHA: begin
        // In grey-alpha mode every second byte is alpha and gives nothing.
        if (cur_mode == MODE_GREY_ALPHA && next_is_alpha) begin
          next_is_alpha = 1'b0;
        end else begin
          for (int k = 0; k < 3; k++) begin
            px.value = data;
            px.last  = (k == 2);
            expected_pixels.push_back(px);
          end
          if (cur_mode == MODE_GREY_ALPHA) begin
            next_is_alpha = 1'b1;
          end
        end
      end
      default: begin
        px.value = data;
        px.last  = 1'b1;
        expected_pixels.push_back(px);
      end
    endcase
    // The last byte of an image always restarts on a grey byte.
    if (last_of_image) begin
      next_is_alpha = 1'b0;
    end
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    if (index == REG_COLOR_MODE) begin
      cur_mode = mode_t'(value);
    end else if (index == REG_DEPTH_CODE) begin
      cur_depth = value;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sends one source byte and waits for its transaction. Valid stays high
  // afterward so that the next byte can follow without a gap.
  task automatic send_byte(input logic [7:0] data, input logic last_of_image);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid     <= 1'b1;
    pix_in.data_byte <= data;
    pix_in.image_end <= last_of_image;
    do begin
      @(posedge clk);
    end while (!pix_in.ready);
    unpack_byte(data, last_of_image);
    bytes_sent++;
  endtask

  // Waits until every expected result has arrived, then lets the block
  // finish any dropped alpha byte still in flight.
  task automatic drain_results();
    pix_in.valid <= 1'b0;
    while (expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected result out_byte=%02h run_last=%0b",
                                  pix_out.out_byte, pix_out.run_last));
      end else begin
        want = expected_pixels.pop_front();
        if (pix_out.out_byte !== want.value) begin
          report_mismatch($sformatf("out_byte %02h, expected %02h",
                                    pix_out.out_byte, want.value));
        end
        if (pix_out.run_last !== want.last) begin
          report_mismatch($sformatf("run_last %0b, expected %0b (out_byte %02h)",
                                    pix_out.run_last, want.last, want.value));
        end
        pixels_checked++;
      end
    end
    pix_out.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Reset values: palette mode at eight bits per pixel.
  task automatic test_reset_state();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b1);
    drain_results();
  endtask

  // Every palette depth, with alternating bit patterns.
  task automatic test_palette_depths();
    logic [1:0] depths[4];
    depths = '{DEPTH_1, DEPTH_2, DEPTH_4, DEPTH_8};
    write_reg(REG_COLOR_MODE, MODE_PALETTE);
    foreach (depths[i]) begin
      write_reg(REG_DEPTH_CODE, depths[i]);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b1);
      drain_results();
    end
  endtask

  task automatic test_grey_copy();
    write_reg(REG_COLOR_MODE, MODE_GREY);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain_results();
  endtask

  // Alpha bytes are dropped; image end restarts on grey, whether the last
  // byte is a grey byte or an alpha byte.
  task automatic test_grey_alpha();
    write_reg(REG_COLOR_MODE, MODE_GREY_ALPHA);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b1);
    send_byte(8'h78, 1'b0);
    send_byte(8'h9A, 1'b1);
    send_byte(8'hBC, 1'b1);
    drain_results();
  endtask

  task automatic test_passthrough();
    write_reg(REG_COLOR_MODE, MODE_PASS);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain_results();
  endtask

  // Depth ignored outside palette mode, alpha phase kept across a mode
  // change, and writes to unused register indexes.
  task automatic test_register_corners();
    write_reg(REG_COLOR_MODE, MODE_GREY);
    write_reg(REG_DEPTH_CODE, DEPTH_1);
    send_byte(8'hC3, 1'b0);
    drain_results();
    write_reg(REG_COLOR_MODE, MODE_GREY_ALPHA);
    send_byte(8'h11, 1'b0);
    drain_results();
    write_reg(REG_COLOR_MODE, MODE_PALETTE);
    send_byte(8'h81, 1'b0);
    drain_results();
    write_reg(REG_COLOR_MODE, MODE_GREY_ALPHA);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b1);
    drain_results();
    write_reg(REG_UNUSED_LO, 2'd3);
    write_reg(REG_UNUSED_HI, 2'd0);
    send_byte(8'h44, 1'b1);
    drain_results();
  endtask

  // Random bytes through every mode and depth; across the four idle phases
  // each mode meets each depth once.
  task automatic test_random_traffic(input int phase);
    for (int blk = 0; blk < 4; blk++) begin
      write_reg(REG_COLOR_MODE, mode_t'((blk + phase) % 4));
      write_reg(REG_DEPTH_CODE, 2'((blk + 2 * phase) % 4));
      for (int n = 0; n < RANDOM_BLOCK; n++) begin
        send_byte(8'($urandom_range(255)), ($urandom_range(7) == 0));
      end
      drain_results();
    end
  endtask

  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    pix_in.valid     <= 1'b0;
    pix_in.data_byte <= '0;
    pix_in.image_end <= 1'b0;
    cur_mode       = MODE_PALETTE;
    cur_depth      = DEPTH_8;
    next_is_alpha  = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    bytes_sent     = 0;
    pixels_checked = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_palette_depths();
    test_grey_copy();
    test_grey_alpha();
    test_passthrough();
    test_register_corners();

    // No idling, sender mostly idle, receiver mostly stalled, both lightly.
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random_traffic(0);
    send_idle_pct = 88; recv_stall_pct = 0;  test_random_traffic(1);
    send_idle_pct = 0;  recv_stall_pct = 88; test_random_traffic(2);
    send_idle_pct = 19; recv_stall_pct = 19; test_random_traffic(3);

    drain_results();
    $display("Covered all color modes and pixel depths with directed and random bytes");
    $display("Sent %0d source bytes, checked %0d result bytes, %0d mismatches",
             bytes_sent, pixels_checked, error_count);
    if (error_count == 0) begin
      $display("tb_packed_pixel_format_unpacker: done, clean");
    end else begin
      $display("tb_packed_pixel_format_unpacker: done, errors");
    end
    $finish;
  end

endmodule
